### sv/moving_average_filter_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the moving average filter
// Wraps concurrent assertions so that a build can leave them out.
// ---------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_FILTER_ASSERT_SVH
`define MOVING_AVERAGE_FILTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled while reset is asserted
`define MAF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("moving_average_filter: assertion failed");

// next-cycle implication, disabled while reset is asserted
`define MAF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("moving_average_filter: assertion failed");

`else

`define MAF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MAF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### sv/maf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Moving average filter package
// Widths, register map, reset values and state type shared by the RTL.
// ---------------------------------------------------------------------------
package maf_pkg;

    // history depth and sample width
    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 12;

    // derived widths
    localparam int SLOT_BITS  = $clog2(MAX_WINDOW);
    localparam int EFF_BITS   = $clog2(MAX_WINDOW + 1);
    localparam int TOTAL_BITS = SAMPLE_BITS + SLOT_BITS;
    localparam int REM_BITS   = $clog2(MAX_WINDOW);
    localparam int CNT_BITS   = $clog2(TOTAL_BITS + 1);

    // configuration register fields and average width
    localparam int WLEN_BITS = 7;
    localparam int MAXD_BITS = 12;
    localparam int AVG_BITS  = 12;

    // APB register map
    localparam int ADDR_BITS = 3;
    localparam int DATA_BITS = 32;

    typedef enum logic [0:0] {
        REG_WINDOW_LENGTH = 1'b0,
        REG_MAX_DISTANCE  = 1'b1
    } t_reg_idx;

    localparam logic [WLEN_BITS-1:0] WLEN_RESET = WLEN_BITS'(8);
    localparam logic [MAXD_BITS-1:0] MAXD_RESET = MAXD_BITS'(400);

    // control sequencer
    typedef enum logic [2:0] {
        ST_PRELOAD,
        ST_IDLE,
        ST_UPDATE,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage : maf_pkg
`default_nettype wire

### sv/maf_smp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one distance sample per beat.
// ---------------------------------------------------------------------------
interface maf_smp_if import maf_pkg::*;;

    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_cm;

    modport source (output valid, output sample_cm, input ready);
    modport sink   (input valid, input sample_cm, output ready);

endinterface : maf_smp_if
`default_nettype wire

### sv/maf_avg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Average channel
// Valid/ready channel carrying one averaged distance per beat.
// ---------------------------------------------------------------------------
interface maf_avg_if import maf_pkg::*;;

    logic                valid;
    logic                ready;
    logic [AVG_BITS-1:0] average_cm;

    modport source (output valid, output average_cm, input ready);
    modport sink   (input valid, input average_cm, output ready);

endinterface : maf_avg_if
`default_nettype wire

### sv/maf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module maf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule : maf_ram
`default_nettype wire

### sv/maf_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Bit-serial divider
// Restoring division, one quotient bit per cycle, dividend shifted out MSB
// first while quotient bits shift in at the bottom of the same register.
// ---------------------------------------------------------------------------
`include "moving_average_filter_assert.svh"

module maf_div import maf_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [TOTAL_BITS-1:0] i_dividend,
    input  wire logic [EFF_BITS-1:0]   i_divisor,
    output logic                       o_done,
    output logic      [TOTAL_BITS-1:0] o_quotient
);

    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(TOTAL_BITS - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [TOTAL_BITS-1:0] r_quo;
    logic [REM_BITS-1:0]   r_rem;
    logic [EFF_BITS-1:0]   r_dvs;

    logic [REM_BITS:0]     trial;
    logic                  fits;
    logic [REM_BITS:0]     diff;
    logic                  last_step;

    // one restoring step: bring down the next dividend bit and try a subtract
    always_comb begin
        trial = {r_rem, r_quo[TOTAL_BITS-1]};
        fits  = (trial >= (REM_BITS + 1)'(r_dvs));
        diff  = trial - (REM_BITS + 1)'(r_dvs);
    end

    // final quotient bit this cycle
    assign last_step = r_busy && (r_cnt == LAST_STEP);

    // control: busy flag, step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last_step) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: shift quotient in, keep the partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[TOTAL_BITS-2:0], fits};
            r_rem <= fits ? diff[REM_BITS-1:0] : trial[REM_BITS-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    `MAF_ASSERT_IMP(a_start_when_free, i_clk, i_rst_n, i_start, !r_busy)
    `MAF_ASSERT_NXT(a_done_after_last, i_clk, i_rst_n, last_step && !i_start, o_done)
    `MAF_ASSERT_IMP(a_quotient_fits, i_clk, i_rst_n, o_done, (o_quotient >> AVG_BITS) == '0)

endmodule : maf_div
`default_nettype wire

### sv/moving_average_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Moving average filter
// Running average of the last N distance samples held in a ring buffer.
// ---------------------------------------------------------------------------
// Usage:
//   Samples arrive on i_smp (valid/ready); each accepted beat yields exactly
//   one average on o_avg, the running total divided by N, truncated.
//   N (window_length, register 0, byte 0) and the preload distance
//   (max_distance, register 1, byte 4) are written over APB; the user
//   must do so only while idle, as the block itself does not enforce it.
// Processing:
//   An accepted sample passes ST_UPDATE (updates ring and total), the
//   bit-serial divider (one quotient bit per cycle over the 18-bit total),
//   ST_DIV (passes the divider's done flag) and ST_DONE (loads the output
//   register). i_smp.ready is high only while no sample is in flight, so
//   a new sample is taken only once the last one's result is loaded.
// Reset and configuration:
//   Reset or any register write preloads the total, in ST_PRELOAD, with
//   max_distance times N; the ring reads as max_distance until written.
// Back-pressure:
//   A result waits in the output register while o_avg.ready is low; a new
//   sample is still accepted, and its result waits until the register frees.
// ---------------------------------------------------------------------------
`include "moving_average_filter_assert.svh"

module moving_average_filter import maf_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    maf_smp_if.sink                   i_smp,
    maf_avg_if.source                 o_avg,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [DATA_BITS-1:0] pwdata,
    output logic      [DATA_BITS-1:0] prdata,
    output logic                      pready
);

    t_state                 r_st, n_st;
    logic [WLEN_BITS-1:0]   r_wlen;
    logic [MAXD_BITS-1:0]   r_maxd;
    logic [TOTAL_BITS-1:0]  r_total, n_total;
    logic [SLOT_BITS-1:0]   r_slot, n_slot;
    logic                   r_filled, n_filled;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_out_valid, n_out_valid;
    logic [AVG_BITS-1:0]    r_avg, n_avg;

    t_reg_idx               reg_idx;
    logic                   cfg_wr;
    logic [EFF_BITS-1:0]    eff_len;
    logic [SAMPLE_BITS-1:0] fill;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic [SAMPLE_BITS-1:0] old_sample;
    logic [EFF_BITS-1:0]    slot_inc;
    logic                   ram_we;
    logic                   div_start;
    logic                   div_done;
    logic [TOTAL_BITS-1:0]  div_quo;
    logic                   smp_acc;

    // register decode
    assign reg_idx = t_reg_idx'(paddr[ADDR_BITS-1]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_WINDOW_LENGTH: prdata = DATA_BITS'(r_wlen);
            REG_MAX_DISTANCE:  prdata = DATA_BITS'(r_maxd);
            default:           prdata = '0;
        endcase
    end

    // clamp the window length to 1..MAX_WINDOW
    always_comb begin
        if (r_wlen == '0) begin
            eff_len = EFF_BITS'(1);
        end else if (EFF_BITS'(r_wlen) > EFF_BITS'(MAX_WINDOW)) begin
            eff_len = EFF_BITS'(MAX_WINDOW);
        end else begin
            eff_len = EFF_BITS'(r_wlen);
        end
    end

    assign fill = SAMPLE_BITS'(r_maxd);

    // an unwritten ring entry reads as the preload value
    assign old_sample = r_filled ? ram_rdata : fill;
    assign slot_inc   = EFF_BITS'(r_slot) + 1'b1;
    assign smp_acc    = i_smp.valid && i_smp.ready;

    // history ring
    maf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_sample),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    // total divided by the window length
    maf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_total),
        .i_divisor  (eff_len),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // sequencer: next state and datapath controls
    always_comb begin
        n_st        = r_st;
        n_total     = r_total;
        n_slot      = r_slot;
        n_filled    = r_filled;
        n_out_valid = r_out_valid;
        n_avg       = r_avg;
        ram_we      = 1'b0;
        div_start   = 1'b0;
        i_smp.ready = 1'b0;

        // drop the result once the sink takes it
        if (r_out_valid && o_avg.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_st)
            ST_PRELOAD: begin
                n_total = TOTAL_BITS'(fill) * TOTAL_BITS'(eff_len);
                n_st    = ST_IDLE;
            end
            ST_IDLE: begin
                i_smp.ready = 1'b1;
                if (i_smp.valid) begin
                    n_st = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // swap oldest sample for the new one and advance the slot
                n_total   = r_total - TOTAL_BITS'(old_sample) + TOTAL_BITS'(r_sample);
                ram_we    = 1'b1;
                div_start = 1'b1;
                if (slot_inc >= eff_len) begin
                    n_slot   = '0;
                    n_filled = 1'b1;
                end else begin
                    n_slot = slot_inc[SLOT_BITS-1:0];
                end
                n_st = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_st = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || o_avg.ready) begin
                    n_out_valid = 1'b1;
                    n_avg       = div_quo[AVG_BITS-1:0];
                    n_st        = ST_IDLE;
                end
            end
            default: begin
                n_st = ST_PRELOAD;
            end
        endcase

        // a register write restarts the filter
        if (cfg_wr) begin
            n_st     = ST_PRELOAD;
            n_slot   = '0;
            n_filled = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_PRELOAD;
            r_wlen      <= WLEN_RESET;
            r_maxd      <= MAXD_RESET;
            r_slot      <= '0;
            r_filled    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_slot      <= n_slot;
            r_filled    <= n_filled;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                case (reg_idx)
                    REG_WINDOW_LENGTH: r_wlen <= pwdata[WLEN_BITS-1:0];
                    REG_MAX_DISTANCE:  r_maxd <= pwdata[MAXD_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_total <= n_total;
        r_avg   <= n_avg;
        if (smp_acc) begin
            r_sample <= i_smp.sample_cm;
        end
    end

    assign o_avg.valid      = r_out_valid;
    assign o_avg.average_cm = r_avg;

    `MAF_ASSERT_NXT(a_accept_updates, i_clk, i_rst_n, smp_acc && !cfg_wr, r_st == ST_UPDATE)
    `MAF_ASSERT_NXT(a_cfg_preloads, i_clk, i_rst_n, cfg_wr, (r_st == ST_PRELOAD) && (r_slot == '0))
    `MAF_ASSERT_IMP(a_slot_in_window, i_clk, i_rst_n, r_st != ST_PRELOAD, EFF_BITS'(r_slot) < eff_len)

endmodule : moving_average_filter
`default_nettype wire
